// ===== sv/dq_pkg.sv =====
package dq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_QUERY      = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  localparam logic signed [31:0] EMPTY_MARK = -32'sd1;

endpackage

// ===== sv/double_ended_queue.sv =====
// Bounded double-ended queue of 32-bit signed words in a circular buffer.
//
// Command channel: a word is taken at a rising edge with start high and
// busy low. in_opcode picks push front, push rear, pop front, pop rear or
// query (unused codes act as a query); in_value is the word to push.
// Result channel: every command gives one result, held on the out_ ports
// for exactly one cycle while out_strobe is high. It shows front and rear
// words after the command (-1 for both when empty), the occupancy, an
// empty flag and a status (done, pop on empty, push on full).
// Pushes, queries and refused commands give their result in the cycle
// after acceptance, and busy stays low, so one command a cycle.
// A pop that leaves words behind must fetch the new front or rear word
// from the slot memory (registered read): its result is registered from
// S_READ once the read data is back, and busy is high for that one read cycle.
// Front and rear words are cached in registers; the memory is written
// only by pushes and read only by pops, so the two never collide.
// Reset (rst_n low, synchronous) empties the queue; slot contents are not
// cleared. The receiver cannot stall: results must be taken when strobed.
module double_ended_queue #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_opcode,
  input  logic signed [31:0]         in_value,
  output logic                       out_strobe,
  output logic signed [31:0]         out_front_value,
  output logic signed [31:0]         out_rear_value,
  output logic [$clog2(DEPTH+1)-1:0] out_occupancy,
  output logic                       out_is_empty,
  output logic [1:0]                 out_status
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - 1'b1;
  endfunction

  state_t               state_r, state_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        tail_r, tail_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic signed [31:0]   front_r, front_nxt;
  logic signed [31:0]   rear_r, rear_nxt;
  logic                 pop_front_r, pop_front_nxt;
  status_t              status_nxt;
  logic                 strobe_r, strobe_nxt;
  logic signed [31:0]   out_front_r, out_rear_r;
  logic [CW-1:0]        out_count_r;
  logic                 out_empty_r;
  status_t              out_status_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [31:0]          ram_rdata;

  logic                 full, empty;
  logic [AW-1:0]        head_prev, head_next, tail_prev;

  assign full      = (count_r == FULL_COUNT);
  assign empty     = (count_r == '0);
  assign head_prev = idx_prev(head_r);
  assign head_next = idx_next(head_r);
  assign tail_prev = idx_prev(tail_r);

  dq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    pop_front_nxt = pop_front_r;
    status_nxt    = STAT_DONE;
    strobe_nxt    = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = tail_r;
    ram_raddr     = head_next;
    busy          = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          strobe_nxt = 1'b1;
          unique case (in_opcode)
            OP_PUSH_FRONT: begin
              if (full) begin
                status_nxt = STAT_PUSH_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = head_prev;
                head_nxt  = head_prev;
                count_nxt = count_r + 1'b1;
                front_nxt = in_value;
                if (empty) begin
                  rear_nxt = in_value;
                end
              end
            end
            OP_PUSH_REAR: begin
              if (full) begin
                status_nxt = STAT_PUSH_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = tail_r;
                tail_nxt  = idx_next(tail_r);
                count_nxt = count_r + 1'b1;
                rear_nxt  = in_value;
                if (empty) begin
                  front_nxt = in_value;
                end
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                status_nxt = STAT_POP_EMPTY;
              end else begin
                head_nxt  = head_next;
                count_nxt = count_r - 1'b1;
                ram_raddr = head_next;
                // new front word has to come from memory
                if (count_r != CW'(1)) begin
                  state_nxt     = S_READ;
                  strobe_nxt    = 1'b0;
                  pop_front_nxt = 1'b1;
                end
              end
            end
            OP_POP_REAR: begin
              if (empty) begin
                status_nxt = STAT_POP_EMPTY;
              end else begin
                tail_nxt  = tail_prev;
                count_nxt = count_r - 1'b1;
                ram_raddr = idx_prev(tail_prev);
                if (count_r != CW'(1)) begin
                  state_nxt     = S_READ;
                  strobe_nxt    = 1'b0;
                  pop_front_nxt = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        if (pop_front_r) begin
          front_nxt = ram_rdata;
        end else begin
          rear_nxt = ram_rdata;
        end
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r     <= front_nxt;
    rear_r      <= rear_nxt;
    pop_front_r <= pop_front_nxt;
    if (strobe_nxt) begin
      out_front_r  <= (count_nxt == '0) ? EMPTY_MARK : front_nxt;
      out_rear_r   <= (count_nxt == '0) ? EMPTY_MARK : rear_nxt;
      out_count_r  <= count_nxt;
      out_empty_r  <= (count_nxt == '0);
      out_status_r <= status_nxt;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_occupancy   = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_status      = out_status_r;

endmodule

// ===== sv/dq_ram.sv =====
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int DEPTH = 64;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_WORDS = 1100;
  localparam int MAX_PRINTED = 40;

  // codes outside the enum; the block treats them as a query
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic signed [31:0] front;
    logic signed [31:0] rear;
    logic [OCC_W-1:0]   occ;
    logic               empty;
    status_t            st;
  } dq_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [2:0]               in_opcode;
  logic signed [31:0]       in_value;
  logic                     out_strobe;
  logic signed [31:0]       out_front_value;
  logic signed [31:0]       out_rear_value;
  logic [OCC_W-1:0]         out_occupancy;
  logic                     out_is_empty;
  logic [1:0]               out_status;

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_front_value(out_front_value),
    .out_rear_value (out_rear_value),
    .out_occupancy  (out_occupancy),
    .out_is_empty   (out_is_empty),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the queue
  logic signed [31:0] shadow_slots [DEPTH];
  int unsigned        shadow_head;
  int unsigned        shadow_tail;
  int unsigned        shadow_count;

  dq_result_t pending_results[$];
  int         error_count;
  int         cycle_count;
  bit         no_idle;

  function automatic int unsigned wrap_next(int unsigned i);
    return (i + 1 >= DEPTH) ? 0 : i + 1;
  endfunction

  function automatic int unsigned wrap_prev(int unsigned i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  function automatic dq_result_t apply_command(logic [2:0] op, logic signed [31:0] val);
    dq_result_t r;
    bit full;
    bit empty;
    full = shadow_count >= DEPTH;
    empty = shadow_count == 0;
    r.st = STAT_DONE;
    if (op == OP_PUSH_FRONT) begin
      if (full) begin
        r.st = STAT_PUSH_FULL;
      end else begin
        shadow_head = wrap_prev(shadow_head);
        shadow_slots[shadow_head] = val;
        shadow_count++;
      end
    end else if (op == OP_PUSH_REAR) begin
      if (full) begin
        r.st = STAT_PUSH_FULL;
      end else begin
        shadow_slots[shadow_tail] = val;
        shadow_tail = wrap_next(shadow_tail);
        shadow_count++;
      end
    end else if (op == OP_POP_FRONT) begin
      if (empty) begin
        r.st = STAT_POP_EMPTY;
      end else begin
        shadow_head = wrap_next(shadow_head);
        shadow_count--;
      end
    end else if (op == OP_POP_REAR) begin
      if (empty) begin
        r.st = STAT_POP_EMPTY;
      end else begin
        shadow_tail = wrap_prev(shadow_tail);
        shadow_count--;
      end
    end
    if (shadow_count == 0) begin
      r.front = EMPTY_MARK;
      r.rear = EMPTY_MARK;
    end else begin
      r.front = shadow_slots[shadow_head];
      r.rear = shadow_slots[wrap_prev(shadow_tail)];
    end
    r.occ = OCC_W'(shadow_count);
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (error_count < MAX_PRINTED) begin
      $display("MISMATCH %s: expected %h got %h at cycle %0d", what, want, got, cycle_count);
    end
    error_count++;
  endtask

  function automatic int idle_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // drives one command word and waits until the block takes it
  task automatic send_word(logic [2:0] op, logic signed [31:0] val);
    int gap;
    start <= 1'b1;
    in_opcode <= op;
    in_value <= val;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    pending_results.push_back(apply_command(op, val));
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      in_opcode <= 3'($urandom);
      in_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    dq_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, out_front_value);
      end else begin
        want = pending_results.pop_front();
        if (out_front_value !== want.front) begin
          report_mismatch("front_value", want.front, out_front_value);
        end
        if (out_rear_value !== want.rear) begin
          report_mismatch("rear_value", want.rear, out_rear_value);
        end
        if (out_occupancy !== want.occ) begin
          report_mismatch("occupancy", 32'(want.occ), 32'(out_occupancy));
        end
        if (out_is_empty !== want.empty) begin
          report_mismatch("is_empty", 32'(want.empty), 32'(out_is_empty));
        end
        if (out_status !== want.st) begin
          report_mismatch("status", 32'(want.st), 32'(out_status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic test_empty_queue();
    send_word(OP_POP_FRONT, rand_word());
    send_word(OP_POP_REAR, rand_word());
    send_word(OP_QUERY, rand_word());
    send_word(OP_SPARE_5, rand_word());
    send_word(OP_SPARE_6, rand_word());
    send_word(OP_SPARE_7, rand_word());
  endtask

  task automatic test_directed_ops();
    send_word(OP_PUSH_REAR, 32'sh7fff_ffff);
    send_word(OP_PUSH_FRONT, 32'sh8000_0000);
    send_word(OP_QUERY, 32'sh1234_5678);
    send_word(OP_PUSH_REAR, 32'sd0);
    send_word(OP_PUSH_FRONT, -32'sd1);
    send_word(OP_POP_REAR, rand_word());
    send_word(OP_POP_FRONT, rand_word());
    send_word(OP_POP_FRONT, rand_word());
    send_word(OP_POP_REAR, rand_word());
    send_word(OP_POP_REAR, rand_word());
    send_word(OP_PUSH_FRONT, 32'sh5555_5555);
    send_word(OP_POP_REAR, rand_word());
    send_word(OP_PUSH_REAR, 32'shAAAA_AAAA);
    send_word(OP_POP_FRONT, rand_word());
    send_word(OP_POP_FRONT, rand_word());
  endtask

  // fill to capacity, hit the full case from both ends, then drain past empty
  task automatic test_fill_drain();
    for (int pass = 0; pass < 3; pass++) begin
      no_idle = (pass == 1);
      while (shadow_count < DEPTH) begin
        send_word($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR, rand_word());
      end
      send_word(OP_PUSH_FRONT, rand_word());
      send_word(OP_PUSH_REAR, rand_word());
      send_word(OP_QUERY, rand_word());
      send_word(OP_POP_FRONT, rand_word());
      send_word(OP_PUSH_REAR, rand_word());
      send_word(OP_PUSH_FRONT, rand_word());
      while (shadow_count > 0) begin
        send_word($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR, rand_word());
      end
      send_word(OP_POP_REAR, rand_word());
      send_word(OP_POP_FRONT, rand_word());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix();
    int push_pct;
    int r;
    logic [2:0] op;
    for (int seg = 0; seg < RANDOM_WORDS / 100; seg++) begin
      case ($urandom_range(0, 4))
        0: push_pct = 20;
        1: push_pct = 50;
        2: push_pct = 80;
        3: push_pct = 95;
        default: push_pct = 5;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          op = 3'(OP_SPARE_5 + $urandom_range(0, 2));
        end else if (r < 8) begin
          op = OP_QUERY;
        end else if ($urandom_range(0, 99) < push_pct) begin
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        end else begin
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
        end
        send_word(op, rand_word());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = '0;
    in_value = '0;
    error_count = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    shadow_head = 0;
    shadow_tail = 0;
    shadow_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_directed_ops();
    test_fill_drain();
    test_random_mix();

    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
